>>> rtl/core/scfe_pkg.sv
// Shared types and constants of the servo command frame encoder.
package scfe_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int COUNT_W     = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_CMD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETALL_CMD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKED_LIMIT = 3'd4;

    localparam logic [7:0]  RST_SET_CMD      = 8'd128;
    localparam logic [7:0]  RST_SETALL_CMD   = 8'd129;
    localparam logic [13:0] RST_SET_LIMIT    = 14'd16383;
    localparam logic [15:0] RST_PULSE_BASE   = 16'd500;
    localparam logic [10:0] RST_PACKED_LIMIT = 11'd2047;

    typedef struct packed {
        logic        func;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [15:0] value;
        logic [6:0]  first_servo;
        logic [6:0]  value_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       frame_error;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  set_command_byte;
        logic [7:0]  setall_command_byte;
        logic [13:0] set_value_limit;
        logic [15:0] pulse_base;
        logic [10:0] packed_value_limit;
    } cfg_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [COUNT_W-1:0]          count;
        logic                        err;
    } job_t;

endpackage

>>> rtl/core/scfe_front.sv
// Front end: accepts input beats, tracks frame state and builds the byte job of each beat.
module scfe_front #(
    parameter int SERVO_COUNT = 18,
    parameter int FIELD_BITS  = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  scfe_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  scfe_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              push,
    output scfe_pkg::job_t    push_job
);

    localparam int ACC_W = 6 + FIELD_BITS;
    localparam int NB_W  = 5;
    localparam logic [6:0]      SERVO_CNT = 7'(SERVO_COUNT);
    localparam logic [NB_W-1:0] FB        = NB_W'(FIELD_BITS);
    localparam logic [NB_W-1:0] ONE_BYTE  = NB_W'(7);
    localparam logic [NB_W-1:0] TWO_BYTES = NB_W'(14);
    localparam logic MODE_SET    = 1'b0;
    localparam logic MODE_SETALL = 1'b1;

    logic       mode_reg, mode_next;
    logic       drop_reg, drop_next;
    logic [5:0] left_bits_reg, left_bits_next;
    logic [2:0] left_cnt_reg, left_cnt_next;

    logic                   accept;
    logic                   first;
    logic                   last;
    logic                   eff_mode;
    logic                   mismatch;
    logic                   skip;
    logic [5:0]             lb;
    logic [2:0]             lc;
    logic [15:0]            set_val;
    logic [15:0]            diff;
    logic [15:0]            clamped;
    logic [FIELD_BITS-1:0]  field;
    logic [ACC_W-1:0]       acc;
    logic [ACC_W-1:0]       aligned;
    logic [ACC_W+6:0]       ext;
    logic [NB_W-1:0]        nbits;
    logic                   two;
    logic [2:0]             rem;
    logic [6:0]             pk0, pk1, pk2;
    logic [5:0]             new_left;
    logic [scfe_pkg::COUNT_W-1:0] n;
    scfe_pkg::job_t         job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign first   = s_data.first_of_frame;
    assign last    = s_data.last_of_frame;

    always_comb begin
        eff_mode = first ? s_data.func : mode_reg;
        mismatch = first && (s_data.func == MODE_SETALL) && (s_data.value_count != SERVO_CNT);
        skip     = !first && drop_reg;
        lb       = (first && s_data.func == MODE_SETALL) ? 6'd0 : left_bits_reg;
        lc       = (first && s_data.func == MODE_SETALL) ? 3'd0 : left_cnt_reg;

        set_val = (s_data.value > {2'b00, cfg.set_value_limit}) ?
                  {2'b00, cfg.set_value_limit} : s_data.value;

        diff    = (s_data.value < cfg.pulse_base) ? 16'd0 : s_data.value - cfg.pulse_base;
        clamped = (diff > {5'd0, cfg.packed_value_limit}) ?
                  {5'd0, cfg.packed_value_limit} : diff;
        field   = FIELD_BITS'(clamped);
        acc     = {lb, field};
        nbits   = NB_W'(lc) + FB;
        two     = nbits >= TWO_BYTES;
        rem     = 3'(nbits - (two ? TWO_BYTES : ONE_BYTE));
        aligned = acc << (3'd6 - lc);
        ext     = {aligned, 7'd0};
        pk0     = ext[ACC_W+6 -: 7];
        pk1     = ext[ACC_W-1 -: 7];
        pk2     = ext[ACC_W-8 -: 7];
        new_left = acc[5:0] & ((6'd1 << rem) - 6'd1);
    end

    always_comb begin
        job = '0;
        n   = '0;
        if (mismatch) begin
            job.bytes[0] = 8'd0;
            job.err      = 1'b1;
            n            = 3'd1;
        end else if (eff_mode == MODE_SET) begin
            if (first) begin
                job.bytes[0] = cfg.set_command_byte;
                job.bytes[1] = {1'b0, s_data.first_servo};
                job.bytes[2] = {1'b0, s_data.value_count};
                n            = 3'd3;
            end
            job.bytes[n] = {1'b0, set_val[6:0]};
            n            = n + 3'd1;
            job.bytes[n] = {1'b0, set_val[13:7]};
            n            = n + 3'd1;
        end else begin
            if (first) begin
                job.bytes[0] = cfg.setall_command_byte;
                n            = 3'd1;
            end
            job.bytes[n] = {1'b0, pk0};
            n            = n + 3'd1;
            if (two) begin
                job.bytes[n] = {1'b0, pk1};
                n            = n + 3'd1;
            end
            if (last && rem != 3'd0) begin
                job.bytes[n] = {1'b0, (two ? pk2 : pk1)};
                n            = n + 3'd1;
            end
        end
        job.count = n;
    end

    assign push     = accept && !skip;
    assign push_job = job;

    always_comb begin
        mode_next      = mode_reg;
        drop_next      = drop_reg;
        left_bits_next = left_bits_reg;
        left_cnt_next  = left_cnt_reg;
        if (accept) begin
            if (first) begin
                mode_next = s_data.func;
                drop_next = 1'b0;
                if (s_data.func == MODE_SETALL) begin
                    left_bits_next = 6'd0;
                    left_cnt_next  = 3'd0;
                end
                if (mismatch) begin
                    drop_next = !last;
                end
            end else if (drop_reg && last) begin
                drop_next = 1'b0;
            end
            if (!mismatch && !skip && eff_mode == MODE_SETALL) begin
                if (last) begin
                    left_bits_next = 6'd0;
                    left_cnt_next  = 3'd0;
                end else begin
                    left_bits_next = new_left;
                    left_cnt_next  = rem;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_SET;
            drop_reg      <= 1'b0;
            left_bits_reg <= 6'd0;
            left_cnt_reg  <= 3'd0;
        end else begin
            mode_reg      <= mode_next;
            drop_reg      <= drop_next;
            left_bits_reg <= left_bits_next;
            left_cnt_reg  <= left_cnt_next;
        end
    end

endmodule

>>> rtl/core/scfe_queue.sv
// Short job queue between the front end and the byte serializer.
module scfe_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scfe_pkg::job_t push_job,
    input  logic           pop,
    output scfe_pkg::job_t head,
    output logic           empty,
    output logic           full
);

    scfe_pkg::job_t mem_reg [scfe_pkg::QUEUE_DEPTH];

    logic [scfe_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [scfe_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [scfe_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        do_push;
    logic                        do_pop;

    assign empty   = cnt_reg == '0;
    assign full    = cnt_reg == scfe_pkg::QCNT_W'(scfe_pkg::QUEUE_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == scfe_pkg::QPTR_W'(scfe_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == scfe_pkg::QPTR_W'(scfe_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/core/scfe_back.sv
// Back end: sends job bytes through an output register, one beat per cycle unless stalled.
module scfe_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  scfe_pkg::job_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output scfe_pkg::out_item_t m_data
);

    logic [scfe_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic                         m_valid_reg, m_valid_next;
    scfe_pkg::out_item_t          m_data_reg, m_data_next;
    logic                         load;
    logic                         at_end;

    assign load   = !empty && (!m_valid_reg || m_ready);
    assign at_end = (idx_reg + 3'd1) == head.count;
    assign pop    = load && at_end;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next            = 1'b1;
            m_data_next.out_byte    = head.bytes[idx_reg];
            m_data_next.end_of_run  = at_end;
            m_data_next.frame_error = head.err;
            idx_next                = at_end ? '0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/servo_command_frame_encoder.sv
// Servo command frame encoder: each input beat carries one servo value and yields the
// frame bytes it causes, one output beat per byte, the last of them flagged end_of_run.
// The front end takes one input beat per cycle while the job queue is not full and turns
// it into a job of one to five bytes in that cycle; a two-entry job queue feeds the
// serializer, which sends one byte per cycle from its output register while m_ready
// allows. An item that opens a SET frame gives five bytes, other SET items two, SETALL
// items one to three, and a count-mismatch error beat one; items dropped from a bad
// frame give nothing. Registers are to be written by the user through the cfg port
// only while the block is idle; the block itself does not enforce this.
module servo_command_frame_encoder #(
    parameter int SERVO_COUNT = 18,
    parameter int FIELD_BITS  = 11
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  scfe_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output scfe_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scfe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    scfe_pkg::cfg_t cfg_reg, cfg_next;
    scfe_pkg::job_t push_job;
    scfe_pkg::job_t head;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                scfe_pkg::CFG_SET_CMD: begin
                    cfg_next.set_command_byte = cfg_wdata[7:0];
                end
                scfe_pkg::CFG_SETALL_CMD: begin
                    cfg_next.setall_command_byte = cfg_wdata[7:0];
                end
                scfe_pkg::CFG_SET_LIMIT: begin
                    cfg_next.set_value_limit = cfg_wdata[13:0];
                end
                scfe_pkg::CFG_PULSE_BASE: begin
                    cfg_next.pulse_base = cfg_wdata[15:0];
                end
                scfe_pkg::CFG_PACKED_LIMIT: begin
                    cfg_next.packed_value_limit = cfg_wdata[10:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_command_byte    <= scfe_pkg::RST_SET_CMD;
            cfg_reg.setall_command_byte <= scfe_pkg::RST_SETALL_CMD;
            cfg_reg.set_value_limit     <= scfe_pkg::RST_SET_LIMIT;
            cfg_reg.pulse_base          <= scfe_pkg::RST_PULSE_BASE;
            cfg_reg.packed_value_limit  <= scfe_pkg::RST_PACKED_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    scfe_front #(
        .SERVO_COUNT (SERVO_COUNT),
        .FIELD_BITS  (FIELD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    scfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    scfe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/core/scfe_checker.sv
// Port-level checker for the servo command frame encoder, bound to the top level.
module scfe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input scfe_pkg::in_item_t              s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input scfe_pkg::out_item_t             m_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [scfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [scfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed or dropped while stalled.");

    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_error |-> m_data.end_of_run && m_data.out_byte == 8'd0)
        else $error("Error beat is not a lone zero byte ending its run.");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready && cfg_ready)
        else $error("Block not ready after reset.");

endmodule

bind servo_command_frame_encoder scfe_checker u_scfe_checker (.*);

>>> tb/servo_command_frame_encoder_tb.sv
// Self-checking testbench for the servo command frame encoder.
`timescale 1ns / 1ps

module servo_command_frame_encoder_tb;

    localparam int SERVO_COUNT  = 18;
    localparam int FIELD_BITS   = 11;
    localparam int PAYLOAD_BITS = 7;
    localparam logic [31:0] PAYLOAD_MASK = 32'h7F;
    localparam logic FRAME_SET    = 1'b0;
    localparam logic FRAME_SETALL = 1'b1;
    localparam int DRAIN_SLACK = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    scfe_pkg::in_item_t    s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    scfe_pkg::out_item_t   m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [scfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [scfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [7:0]  cmd_set_byte = scfe_pkg::RST_SET_CMD;
    logic [7:0]  cmd_setall_byte = scfe_pkg::RST_SETALL_CMD;
    logic [13:0] set_limit = scfe_pkg::RST_SET_LIMIT;
    logic [15:0] base_us = scfe_pkg::RST_PULSE_BASE;
    logic [10:0] pack_limit = scfe_pkg::RST_PACKED_LIMIT;

    logic [5:0]  spill_bits = '0;
    logic [2:0]  spill_count = '0;
    logic        dropping = 1'b0;
    logic        mode = FRAME_SET;

    scfe_pkg::out_item_t frame_bytes_due[$];
    scfe_pkg::out_item_t want_beat;

    int  errors = 0;
    int  cycles = 0;
    int  beats_in = 0;
    int  items_with_bytes = 0;
    int  beats_checked = 0;
    int  settings_used = 0;
    int  stall_request = 0;
    bit  tx_idling = 1'b1;
    bit  rx_idling = 1'b1;

    servo_command_frame_encoder #(
        .SERVO_COUNT(SERVO_COUNT),
        .FIELD_BITS (FIELD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic scfe_pkg::out_item_t beat(input logic [7:0] b);
        scfe_pkg::out_item_t r;
        r.out_byte = b;
        r.end_of_run = 1'b0;
        r.frame_error = 1'b0;
        return r;
    endfunction

    function automatic scfe_pkg::in_item_t mk(input logic kind, input logic first,
                                              input logic last, input logic [15:0] value,
                                              input logic [6:0] start,
                                              input logic [6:0] declared);
        scfe_pkg::in_item_t it;
        it.func = kind;
        it.first_of_frame = first;
        it.last_of_frame = last;
        it.value = value;
        it.first_servo = start;
        it.value_count = declared;
        return it;
    endfunction

    function automatic int predict_frame_bytes(input scfe_pkg::in_item_t it);
        scfe_pkg::out_item_t res [scfe_pkg::MAX_RESULTS];
        int          n;
        int          nbits;
        logic [15:0] clamped;
        logic [31:0] field;
        logic [31:0] acc;
        n = 0;
        if (!it.first_of_frame && dropping) begin
            if (it.last_of_frame) dropping = 1'b0;
        end else if (it.first_of_frame && it.func == FRAME_SETALL
                     && int'(it.value_count) != SERVO_COUNT) begin
            mode = FRAME_SETALL;
            spill_bits = '0;
            spill_count = '0;
            dropping = !it.last_of_frame;
            res[0] = beat(8'h00);
            res[0].frame_error = 1'b1;
            n = 1;
        end else begin
            if (it.first_of_frame) begin
                mode = it.func;
                dropping = 1'b0;
                if (mode == FRAME_SETALL) begin
                    spill_bits = '0;
                    spill_count = '0;
                end
            end
            if (mode == FRAME_SET) begin
                clamped = (it.value > {2'b00, set_limit}) ? {2'b00, set_limit} : it.value;
                if (it.first_of_frame) begin
                    res[0] = beat(cmd_set_byte);
                    res[1] = beat({1'b0, it.first_servo});
                    res[2] = beat({1'b0, it.value_count});
                    n = 3;
                end
                res[n] = beat({1'b0, clamped[6:0]});
                res[n + 1] = beat({1'b0, clamped[13:7]});
                n = n + 2;
            end else begin
                clamped = (it.value < base_us) ? 16'd0 : it.value - base_us;
                if (clamped > {5'd0, pack_limit}) clamped = {5'd0, pack_limit};
                field = 32'(clamped) & ((32'd1 << FIELD_BITS) - 32'd1);
                if (it.first_of_frame) begin
                    res[n] = beat(cmd_setall_byte);
                    n = n + 1;
                end
                acc = (32'(spill_bits) << FIELD_BITS) | field;
                nbits = int'(spill_count) + FIELD_BITS;
                while (nbits >= PAYLOAD_BITS) begin
                    res[n] = beat(8'((acc >> (nbits - PAYLOAD_BITS)) & PAYLOAD_MASK));
                    n = n + 1;
                    nbits = nbits - PAYLOAD_BITS;
                end
                acc = acc & ((32'd1 << nbits) - 32'd1);
                if (it.last_of_frame) begin
                    if (nbits > 0) begin
                        res[n] = beat(8'((acc << (PAYLOAD_BITS - nbits)) & PAYLOAD_MASK));
                        n = n + 1;
                    end
                    spill_bits = '0;
                    spill_count = '0;
                end else begin
                    spill_bits = acc[5:0];
                    spill_count = 3'(nbits);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) res[i].end_of_run = 1'b1;
            frame_bytes_due = {frame_bytes_due, res[i]};
        end
        return n;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected beat: out_byte %0h end_of_run %0b frame_error %0b",
                       m_data.out_byte, m_data.end_of_run, m_data.frame_error);
                errors++;
            end else begin
                want_beat = frame_bytes_due.pop_front();
                beats_checked++;
                if (m_data.out_byte !== want_beat.out_byte) begin
                    $error("out_byte: expected %0h, got %0h",
                           want_beat.out_byte, m_data.out_byte);
                    errors++;
                end
                if (m_data.end_of_run !== want_beat.end_of_run) begin
                    $error("end_of_run: expected %0b, got %0b",
                           want_beat.end_of_run, m_data.end_of_run);
                    errors++;
                end
                if (m_data.frame_error !== want_beat.frame_error) begin
                    $error("frame_error: expected %0b, got %0b",
                           want_beat.frame_error, m_data.frame_error);
                    errors++;
                end
            end
        end
    end

    initial begin : receiver
        int n;
        forever begin
            @(posedge aclk);
            if (stall_request != 0) begin
                n = stall_request;
                stall_request = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (rx_idling && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input scfe_pkg::in_item_t it);
        if (tx_idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        beats_in++;
        if (predict_frame_bytes(it) > 0) items_with_bytes++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_beat(input logic [scfe_pkg::CFG_IDX_W-1:0] idx,
                              input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            scfe_pkg::CFG_SET_CMD:      cmd_set_byte = data[7:0];
            scfe_pkg::CFG_SETALL_CMD:   cmd_setall_byte = data[7:0];
            scfe_pkg::CFG_SET_LIMIT:    set_limit = data[13:0];
            scfe_pkg::CFG_PULSE_BASE:   base_us = data;
            scfe_pkg::CFG_PACKED_LIMIT: pack_limit = data[10:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] w_set_cmd, input logic [15:0] w_setall_cmd,
                                  input logic [15:0] w_set_limit, input logic [15:0] w_base,
                                  input logic [15:0] w_pack_limit);
        write_beat(scfe_pkg::CFG_SET_CMD, w_set_cmd);
        write_beat(scfe_pkg::CFG_SETALL_CMD, w_setall_cmd);
        write_beat(scfe_pkg::CFG_SET_LIMIT, w_set_limit);
        write_beat(scfe_pkg::CFG_PULSE_BASE, w_base);
        write_beat(scfe_pkg::CFG_PACKED_LIMIT, w_pack_limit);
        write_beat(scfe_pkg::CFG_IDX_W'(scfe_pkg::CFG_PACKED_LIMIT + 1 + $urandom_range(0, 2)),
                   16'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return base_us + 16'($urandom_range(0, 2200));
            2: return 16'($urandom_range(0, 20000));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic send_frame(input logic kind, input int declared, input int beats);
        logic [6:0] start;
        start = 7'($urandom);
        for (int i = 0; i < beats; i++) begin
            if (i == 0)
                send_item(mk(kind, 1'b1, beats == 1, pick_value(), start, 7'(declared)));
            else
                send_item(mk(kind, 1'b0, i == beats - 1, pick_value(), 7'($urandom),
                             7'($urandom)));
        end
    endtask

    task automatic test_directed_cases();
        send_item(mk(FRAME_SETALL, 1'b0, 1'b0, 16'h1234, 7'd5, 7'd9));
        send_item(mk(FRAME_SET, 1'b1, 1'b0, 16'hFFFF, 7'd0, 7'd0));
        send_item(mk(FRAME_SET, 1'b0, 1'b0, 16'd16383, 7'd0, 7'd0));
        send_item(mk(FRAME_SET, 1'b0, 1'b1, 16'd0, 7'd0, 7'd0));
        send_item(mk(FRAME_SET, 1'b1, 1'b1, 16'd128, 7'h7F, 7'h7F));
        send_item(mk(FRAME_SETALL, 1'b1, 1'b0, 16'd0, 7'd0, 7'(SERVO_COUNT)));
        send_item(mk(FRAME_SETALL, 1'b0, 1'b0, 16'd500, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b0, 1'b0, 16'd2547, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b0, 1'b0, 16'hFFFF, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b0, 1'b1, 16'd1234, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b1, 1'b1, 16'd700, 7'd0, 7'(SERVO_COUNT)));
        send_item(mk(FRAME_SETALL, 1'b1, 1'b0, 16'd600, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b0, 1'b0, 16'd800, 7'd0, 7'd0));
        send_item(mk(FRAME_SET, 1'b0, 1'b1, 16'd800, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b0, 1'b0, 16'd900, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b1, 1'b0, 16'd600, 7'd0, 7'h7F));
        send_item(mk(FRAME_SET, 1'b1, 1'b1, 16'd300, 7'd3, 7'd2));
        send_item(mk(FRAME_SETALL, 1'b1, 1'b1, 16'd1000, 7'd0, 7'(SERVO_COUNT - 1)));
        send_item(mk(FRAME_SET, 1'b0, 1'b1, 16'd1500, 7'd0, 7'd0));
        send_item(mk(FRAME_SETALL, 1'b1, 1'b1, 16'hFFFF, 7'h7F, 7'h7F));
        send_item(mk(FRAME_SET, 1'b0, 1'b0, 16'h0000, 7'h00, 7'h00));
        send_item(mk(FRAME_SET, 1'b1, 1'b1, 16'hFFFF, 7'h7F, 7'h7F));
        wait_drained();
    endtask

    task automatic test_register_settings();
        for (int k = 0; k < 4; k++) begin
            wait_drained();
            case (k)
                0: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom_range(0, 3000)), 16'($urandom));
                default: apply_settings(scfe_pkg::RST_SET_CMD, scfe_pkg::RST_SETALL_CMD,
                                        scfe_pkg::RST_SET_LIMIT, scfe_pkg::RST_PULSE_BASE,
                                        scfe_pkg::RST_PACKED_LIMIT);
            endcase
            send_frame(FRAME_SET, 3, 3);
            send_frame(FRAME_SETALL, SERVO_COUNT, 6);
            send_frame(FRAME_SETALL, SERVO_COUNT, 1);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idling = 1'b0;
        stall_request = 80;
        for (int k = 0; k < 4; k++) send_frame(FRAME_SET, 5, 5);
        send_frame(FRAME_SETALL, SERVO_COUNT, 4);
        wait_drained();
        tx_idling = 1'b1;
    endtask

    task automatic test_random_frames(input int target, input bit calm_tail);
        int goal;
        int declared;
        wait_drained();
        apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom_range(0, 4000)), 16'($urandom));
        goal = items_with_bytes + target;
        while (items_with_bytes < goal) begin
            if (calm_tail && items_with_bytes > goal - target / 3) begin
                tx_idling = 1'b0;
                rx_idling = 1'b0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    declared = $urandom_range(0, 6);
                    send_frame(FRAME_SET, declared, ($urandom_range(0, 3) == 0 || declared == 0)
                               ? $urandom_range(1, 8) : declared);
                end
                4, 5, 6, 7: begin
                    declared = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                            : SERVO_COUNT;
                    send_frame(FRAME_SETALL, declared, ($urandom_range(0, 3) == 0)
                               ? $urandom_range(1, 20) : SERVO_COUNT);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) send_item(scfe_pkg::in_item_t'($urandom));
                end
            endcase
            if ($urandom_range(0, 11) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_register_settings();
        test_backpressure();
        test_random_frames(50, 1'b0);
        test_random_frames(50, 1'b1);
        $display("Sent %0d input beats (%0d producing bytes) under %0d register settings;",
                 beats_in, items_with_bytes, settings_used);
        $display("checked %0d output beats, %0d mismatches.", beats_checked, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> servo_command_frame_encoder.f
rtl/core/scfe_pkg.sv
rtl/core/scfe_front.sv
rtl/core/scfe_queue.sv
rtl/core/scfe_back.sv
rtl/core/servo_command_frame_encoder.sv
rtl/core/scfe_checker.sv
tb/servo_command_frame_encoder_tb.sv
